[rtl/mmie_pkg.sv]
// package for the memory-to-memory instruction executor
// holds the memory size, field widths, operation codes and shared types
// no dependencies
`default_nettype none

package mmie_pkg;

   localparam int unsigned DATA_WORDS = 1024;
   localparam int unsigned MEM_AW     = $clog2(DATA_WORDS);
   localparam int unsigned ADDR_W     = 10;
   localparam int unsigned OP_W       = 3;
   localparam int unsigned WORD_W     = 32;

   typedef enum logic [OP_W-1:0] {
      OP_ADD   = 3'd0,
      OP_SUB   = 3'd1,
      OP_STORE = 3'd2,
      OP_LOAD  = 3'd3,
      OP_HALT  = 3'd4
   } op_type;

   typedef struct packed {
      logic              active;
      logic [MEM_AW-1:0] index;
   } clr_status_type;

   typedef struct packed {
      logic              en;
      logic [MEM_AW-1:0] addr;
      logic [WORD_W-1:0] data;
   } mem_wr_type;

   function automatic logic addr_ok(input logic [ADDR_W-1:0] a);
      return 32'(a) < 32'(DATA_WORDS);
   endfunction

   function automatic logic [MEM_AW-1:0] mem_index(input logic [ADDR_W-1:0] a);
      logic [31:0] w;
      w = 32'(a);
      return w[MEM_AW-1:0];
   endfunction

endpackage

`default_nettype wire

[rtl/mmie_ram.sv]
// generic single-write, single-read synchronous ram
// read data registered; no dependencies
`default_nettype none

module mmie_ram #(
   parameter int unsigned WIDTH = 32,
   parameter int unsigned DEPTH = 1024
) (
   input  wire logic                     clock,
   input  wire logic                     we,
   input  wire logic [$clog2(DEPTH)-1:0] waddr,
   input  wire logic [WIDTH-1:0]         wdata,
   input  wire logic [$clog2(DEPTH)-1:0] raddr,
   output logic      [WIDTH-1:0]         rdata
);

   logic [WIDTH-1:0] mem [DEPTH];

   always_ff @(posedge clock) begin
      if (we) begin
         mem[waddr] <= wdata;
      end
      rdata <= mem[raddr];
   end

endmodule

`default_nettype wire

[rtl/mmie_clear.sv]
// clearing sweep that zeroes the data memory after reset
// depends on mmie_pkg
`default_nettype none

module mmie_clear
   import mmie_pkg::*;
(
   input  wire logic     clock,
   input  wire logic     reset,
   output clr_status_type status
);

   logic              active_ff, active_in;
   logic [MEM_AW-1:0] index_ff, index_in;

   always_comb begin
      active_in = active_ff;
      index_in  = index_ff;
      if (active_ff) begin
         if (index_ff == MEM_AW'(DATA_WORDS - 1)) begin
            active_in = 1'b0;
         end else begin
            index_in = index_ff + MEM_AW'(1);
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         active_ff <= 1'b1;
         index_ff  <= '0;
      end else begin
         active_ff <= active_in;
         index_ff  <= index_in;
      end
   end

   assign status.active = active_ff;
   assign status.index  = index_ff;

endmodule

`default_nettype wire

[rtl/mmie_exec.sv]
// two-stage execute pipeline: read issue, then compute, write back and respond
// forwards the previous cycle's write; depends on mmie_pkg
`default_nettype none

module mmie_exec
   import mmie_pkg::*;
(
   input  wire logic                     clock,
   input  wire logic                     reset,
   input  wire logic                     accept,
   input  wire logic [OP_W-1:0]          operation,
   input  wire logic [ADDR_W-1:0]        first_address,
   input  wire logic [ADDR_W-1:0]        second_address,
   input  wire logic [ADDR_W-1:0]        dest_address,
   input  wire logic signed [WORD_W-1:0] immediate_value,
   output logic      [MEM_AW-1:0]        rd_addr_a,
   output logic      [MEM_AW-1:0]        rd_addr_b,
   input  wire logic [WORD_W-1:0]        rd_data_a,
   input  wire logic [WORD_W-1:0]        rd_data_b,
   output mem_wr_type                    wr,
   output logic                          rsp_strobe,
   output logic signed [WORD_W-1:0]      rsp_value,
   output logic                          rsp_halted
);

   logic              valid_ff;
   logic [OP_W-1:0]   op_ff;
   logic [ADDR_W-1:0] src_a_ff, src_b_ff, dst_ff;
   logic [WORD_W-1:0] imm_ff;

   logic              fwd_valid_ff;
   logic [MEM_AW-1:0] fwd_addr_ff;
   logic [WORD_W-1:0] fwd_data_ff;

   logic              strobe_ff;
   logic [WORD_W-1:0] value_ff, value_in;
   logic              halted_ff, halted_in;

   logic [WORD_W-1:0] x, y;
   logic              writes;

   assign rd_addr_a = mem_index(first_address);
   assign rd_addr_b = mem_index(second_address);

   // operand select with bypass of the write made in the previous cycle
   always_comb begin
      if (!addr_ok(src_a_ff)) begin
         x = '0;
      end else if (fwd_valid_ff && fwd_addr_ff == mem_index(src_a_ff)) begin
         x = fwd_data_ff;
      end else begin
         x = rd_data_a;
      end
      if (!addr_ok(src_b_ff)) begin
         y = '0;
      end else if (fwd_valid_ff && fwd_addr_ff == mem_index(src_b_ff)) begin
         y = fwd_data_ff;
      end else begin
         y = rd_data_b;
      end
   end

   always_comb begin
      value_in  = '0;
      halted_in = 1'b0;
      writes    = 1'b0;
      unique case (op_type'(op_ff))
         OP_ADD: begin
            value_in = x + y;
            writes   = 1'b1;
         end
         OP_SUB: begin
            value_in = x - y;
            writes   = 1'b1;
         end
         OP_STORE: begin
            value_in = imm_ff;
            writes   = 1'b1;
         end
         OP_LOAD: begin
            value_in = x;
         end
         OP_HALT: begin
            halted_in = 1'b1;
         end
         default: begin
            value_in = '0;
         end
      endcase
   end

   assign wr.en   = valid_ff && writes && addr_ok(dst_ff);
   assign wr.addr = mem_index(dst_ff);
   assign wr.data = value_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff     <= 1'b0;
         fwd_valid_ff <= 1'b0;
         strobe_ff    <= 1'b0;
      end else begin
         valid_ff     <= accept;
         fwd_valid_ff <= wr.en;
         strobe_ff    <= valid_ff;
      end
      op_ff       <= operation;
      src_a_ff    <= first_address;
      src_b_ff    <= second_address;
      dst_ff      <= dest_address;
      imm_ff      <= immediate_value;
      fwd_addr_ff <= wr.addr;
      fwd_data_ff <= wr.data;
      value_ff    <= value_in;
      halted_ff   <= halted_in;
   end

   assign rsp_strobe = strobe_ff;
   assign rsp_value  = value_ff;
   assign rsp_halted = halted_ff;

endmodule

`default_nettype wire

[rtl/memory_to_memory_instruction_executor_top.sv]
// channel    ports                                   handshake
// request    req_operation .. req_immediate_value    req_start high, busy low
// result     rsp_value, rsp_halted                   rsp_strobe, one cycle
//
// one request per cycle while busy is low; each result passes the execute registers, then the result register
// throughput is set by the two copies of the data memory, one per source port
// after reset, busy stays high while the sweep zeroes all DATA_WORDS (1024) words of memory
// a write is bypassed to the request that follows it directly
// the receiver cannot stall; no result is held back
//
// top level: clearing sweep, execute pipeline and two ram copies
// depends on mmie_pkg, mmie_ram, mmie_clear, mmie_exec
`default_nettype none

module memory_to_memory_instruction_executor_top
   import mmie_pkg::*;
(
   input  wire logic                     clock,
   input  wire logic                     reset,
   input  wire logic                     req_start,
   output logic                          busy,
   input  wire logic [OP_W-1:0]          req_operation,
   input  wire logic [ADDR_W-1:0]        req_first_address,
   input  wire logic [ADDR_W-1:0]        req_second_address,
   input  wire logic [ADDR_W-1:0]        req_dest_address,
   input  wire logic signed [WORD_W-1:0] req_immediate_value,
   output logic                          rsp_strobe,
   output logic signed [WORD_W-1:0]      rsp_value,
   output logic                          rsp_halted
);

   clr_status_type    clr;
   mem_wr_type        exec_wr;
   logic [MEM_AW-1:0] rd_addr_a, rd_addr_b;
   logic [WORD_W-1:0] rd_data_a, rd_data_b;
   logic              ram_we;
   logic [MEM_AW-1:0] ram_waddr;
   logic [WORD_W-1:0] ram_wdata;
   logic              accept;

   assign busy   = clr.active;
   assign accept = req_start && !clr.active;

   mmie_clear u_clear (
      .clock  (clock),
      .reset  (reset),
      .status (clr)
   );

   mmie_exec u_exec (
      .clock           (clock),
      .reset           (reset),
      .accept          (accept),
      .operation       (req_operation),
      .first_address   (req_first_address),
      .second_address  (req_second_address),
      .dest_address    (req_dest_address),
      .immediate_value (req_immediate_value),
      .rd_addr_a       (rd_addr_a),
      .rd_addr_b       (rd_addr_b),
      .rd_data_a       (rd_data_a),
      .rd_data_b       (rd_data_b),
      .wr              (exec_wr),
      .rsp_strobe      (rsp_strobe),
      .rsp_value       (rsp_value),
      .rsp_halted      (rsp_halted)
   );

   // clearing sweep owns the write port until it finishes
   always_comb begin
      if (clr.active) begin
         ram_we    = 1'b1;
         ram_waddr = clr.index;
         ram_wdata = '0;
      end else begin
         ram_we    = exec_wr.en;
         ram_waddr = exec_wr.addr;
         ram_wdata = exec_wr.data;
      end
   end

   mmie_ram #(
      .WIDTH (WORD_W),
      .DEPTH (DATA_WORDS)
   ) u_ram_a (
      .clock (clock),
      .we    (ram_we),
      .waddr (ram_waddr),
      .wdata (ram_wdata),
      .raddr (rd_addr_a),
      .rdata (rd_data_a)
   );

   mmie_ram #(
      .WIDTH (WORD_W),
      .DEPTH (DATA_WORDS)
   ) u_ram_b (
      .clock (clock),
      .we    (ram_we),
      .waddr (ram_waddr),
      .wdata (ram_wdata),
      .raddr (rd_addr_b),
      .rdata (rd_data_b)
   );

endmodule

`default_nettype wire

[rtl/mmie_checker.sv]
// port-level checks for the instruction executor, bound to the top level
// depends on mmie_pkg and memory_to_memory_instruction_executor_top
`default_nettype none

module mmie_checker
   import mmie_pkg::*;
(
   input wire logic                     clock,
   input wire logic                     reset,
   input wire logic                     req_start,
   input wire logic                     busy,
   input wire logic [OP_W-1:0]          req_operation,
   input wire logic signed [WORD_W-1:0] req_immediate_value,
   input wire logic                     rsp_strobe,
   input wire logic signed [WORD_W-1:0] rsp_value,
   input wire logic                     rsp_halted
);

   // every accepted request gives exactly one result, and no result comes without one
   a_one_result: assert property (@(posedge clock) disable iff (reset)
      !$past(reset) && !$past(reset, 2)
      |-> rsp_strobe == $past(req_start && !busy, 2))
      else $error("result strobe does not follow request");

   a_halt_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_strobe && rsp_halted |-> rsp_value == '0)
      else $error("halt result carries a nonzero value");

   a_store_echo: assert property (@(posedge clock) disable iff (reset)
      !$past(reset) && !$past(reset, 2)
      && $past(req_start && !busy && req_operation == OP_STORE, 2)
      |-> rsp_value == $past(req_immediate_value, 2) && !rsp_halted)
      else $error("store immediate result differs from request");

   a_clear_after_reset: assert property (@(posedge clock)
      $past(reset) && !reset |-> busy)
      else $error("memory clear not running after reset");

   a_busy_stays_low: assert property (@(posedge clock) disable iff (reset)
      !$past(reset) && !$past(busy) |-> !busy)
      else $error("busy rose outside reset");

endmodule

bind memory_to_memory_instruction_executor_top mmie_checker u_mmie_checker (
   .clock               (clock),
   .reset               (reset),
   .req_start           (req_start),
   .busy                (busy),
   .req_operation       (req_operation),
   .req_immediate_value (req_immediate_value),
   .rsp_strobe          (rsp_strobe),
   .rsp_value           (rsp_value),
   .rsp_halted          (rsp_halted)
);

`default_nettype wire
